@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property checked on every rising clock edge outside reset
`define TRQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition that must hold on every rising clock edge outside reset
`define TRQ_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`else
`define TRQ_ASSERT(label, prop, msg)
`define TRQ_ASSERT_ALWAYS(label, cond, msg)
`endif
`endif

@@ hw/rtl/trq_pkg.sv @@
// types, constants and helpers of the thread ready queue
package trq_pkg;

    localparam int THREAD_SLOTS = 64;
    localparam int ID_W         = 6;
    localparam int SLOT_W       = $clog2(THREAD_SLOTS);
    localparam int COUNT_W      = 7;
    localparam int ACT_W        = 2;

    typedef logic [ID_W-1:0]    id_t;
    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUT    = 2'd0,
        ACT_GET    = 2'd1,
        ACT_REMOVE = 2'd2
    } action_t;

    localparam id_t IDLE_RESET = id_t'(1);

    typedef struct packed {
        logic [ACT_W-1:0] action;
        id_t              id;
    } item_t;

    typedef struct packed {
        id_t                     head;
        id_t                     tail;
        count_t                  count;
        logic [THREAD_SLOTS-1:0] inq;
    } state_t;

    typedef struct packed {
        state_t st;
        logic   n_we;
        slot_t  n_waddr;
        id_t    n_wdata;
        logic   p_we;
        slot_t  p_waddr;
        id_t    p_wdata;
        id_t    result;
        logic   was_idle;
        logic   status;
    } upd_t;

    function automatic logic id_in_range(id_t v);
        return int'(v) < THREAD_SLOTS;
    endfunction

    function automatic slot_t to_slot(id_t v);
        return id_in_range(v) ? slot_t'(v) : '0;
    endfunction

endpackage

@@ hw/rtl/trq_ram.sv @@
// generic single write, single read ram with registered read data
module trq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/trq_update.sv @@
// next queue state, link writes and result for one operation
module trq_update (
    input  trq_pkg::item_t  item,
    input  trq_pkg::state_t st,
    input  trq_pkg::id_t    idle,
    input  trq_pkg::id_t    next_rd,
    input  trq_pkg::id_t    prev_rd,
    output trq_pkg::upd_t   upd
);

    always_comb
    begin
        trq_pkg::slot_t ids;
        trq_pkg::slot_t h;
        trq_pkg::slot_t nx;
        trq_pkg::slot_t pv;
        logic           id_ok;

        ids   = trq_pkg::to_slot(item.id);
        id_ok = trq_pkg::id_in_range(item.id);
        h     = trq_pkg::to_slot(st.head);
        nx    = trq_pkg::to_slot(next_rd);
        pv    = trq_pkg::to_slot(prev_rd);

        upd          = '0;
        upd.st       = st;
        upd.n_waddr  = trq_pkg::to_slot(st.tail);
        upd.n_wdata  = item.id;
        upd.p_waddr  = ids;
        upd.p_wdata  = st.tail;
        upd.result   = item.id;
        upd.was_idle = 1'b0;
        upd.status   = 1'b1;

        case (item.action)
            trq_pkg::ACT_PUT:
            begin
                if (item.id != '0 && item.id != idle && id_ok && !st.inq[ids])
                begin
                    if (st.count == '0)
                    begin
                        upd.st.head = item.id;
                    end
                    else
                    begin
                        // link behind the current tail
                        upd.n_we = 1'b1;
                        upd.p_we = 1'b1;
                    end
                    upd.st.tail     = item.id;
                    upd.st.inq[ids] = 1'b1;
                    upd.st.count    = trq_pkg::count_t'(st.count + 1'b1);
                    upd.status      = 1'b0;
                end
            end
            trq_pkg::ACT_GET:
            begin
                upd.status = 1'b0;
                if (st.count == '0)
                begin
                    upd.result   = idle;
                    upd.was_idle = 1'b1;
                end
                else
                begin
                    upd.result    = trq_pkg::id_t'(h);
                    upd.st.inq[h] = 1'b0;
                    upd.st.count  = trq_pkg::count_t'(st.count - 1'b1);
                    if (st.count == trq_pkg::count_t'(1))
                    begin
                        upd.st.head = '0;
                        upd.st.tail = '0;
                    end
                    else
                    begin
                        upd.st.head = trq_pkg::id_t'(nx);
                    end
                end
            end
            trq_pkg::ACT_REMOVE:
            begin
                if (id_ok && st.inq[ids])
                begin
                    if (item.id == st.head)
                    begin
                        upd.st.head = trq_pkg::id_t'(nx);
                    end
                    else
                    begin
                        upd.n_we    = 1'b1;
                        upd.n_waddr = pv;
                        upd.n_wdata = trq_pkg::id_t'(nx);
                    end
                    if (item.id == st.tail)
                    begin
                        upd.st.tail = trq_pkg::id_t'(pv);
                    end
                    else
                    begin
                        upd.p_we    = 1'b1;
                        upd.p_waddr = nx;
                        upd.p_wdata = trq_pkg::id_t'(pv);
                    end
                    upd.st.inq[ids] = 1'b0;
                    upd.st.count    = trq_pkg::count_t'(st.count - 1'b1);
                    if (st.count == trq_pkg::count_t'(1))
                    begin
                        upd.st.head = '0;
                        upd.st.tail = '0;
                    end
                    upd.status = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ hw/rtl/thread_ready_queue_core.sv @@
// top level of the thread ready queue: input register, update logic, result register
// result path: accepted beat -> input register -> update logic -> result register
// throughput: one operation per cycle unless out_stall holds the result, set by the
// link rams' single read port each; link reads are launched when a beat is accepted,
// with a one-deep bypass from the operation retiring in the same cycle
// reset: queue empty, idle id 1, links left unwritten (no clearing pass)
`include "assert_macros.svh"

module thread_ready_queue_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [trq_pkg::ID_W-1:0]   idle_id,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [trq_pkg::ACT_W-1:0]  action,
    input  logic [trq_pkg::ID_W-1:0]   thread_id,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [trq_pkg::ID_W-1:0]   result_id,
    output logic                       was_idle,
    output logic                       status,
    output logic [trq_pkg::COUNT_W-1:0] queued_count
);

    trq_pkg::item_t  item_reg;
    logic            inv_reg;
    trq_pkg::state_t st_reg;
    trq_pkg::id_t    idle_reg;

    logic            byp_n_reg;
    trq_pkg::id_t    byp_nd_reg;
    logic            byp_p_reg;
    trq_pkg::id_t    byp_pd_reg;

    logic            outv_reg;
    trq_pkg::id_t    result_reg;
    logic            was_idle_reg;
    logic            status_reg;
    trq_pkg::count_t count_out_reg;

    trq_pkg::upd_t   upd;
    trq_pkg::id_t    n_rdata;
    trq_pkg::id_t    p_rdata;
    trq_pkg::id_t    next_rd;
    trq_pkg::id_t    prev_rd;
    trq_pkg::id_t    head_cur;
    trq_pkg::slot_t  n_raddr;
    trq_pkg::slot_t  p_raddr;
    logic            adv;
    logic            accept;

    assign adv      = inv_reg && (!outv_reg || !out_stall);
    assign in_stall = inv_reg && !adv;
    assign accept   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign next_rd = byp_n_reg ? byp_nd_reg : n_rdata;
    assign prev_rd = byp_p_reg ? byp_pd_reg : p_rdata;

    // a get reads the link of the head as it stands after the retiring operation
    assign head_cur = inv_reg ? upd.st.head : st_reg.head;
    assign n_raddr  = (action == trq_pkg::ACT_GET) ? trq_pkg::to_slot(head_cur)
                                                   : trq_pkg::to_slot(thread_id);
    assign p_raddr  = trq_pkg::to_slot(thread_id);

    trq_update u_update (
        .item    (item_reg),
        .st      (st_reg),
        .idle    (idle_reg),
        .next_rd (next_rd),
        .prev_rd (prev_rd),
        .upd     (upd)
    );

    trq_ram #(
        .WIDTH (trq_pkg::ID_W),
        .DEPTH (trq_pkg::THREAD_SLOTS)
    ) u_next_ram (
        .clk   (clk),
        .we    (adv && upd.n_we),
        .waddr (upd.n_waddr),
        .wdata (upd.n_wdata),
        .re    (accept),
        .raddr (n_raddr),
        .rdata (n_rdata)
    );

    trq_ram #(
        .WIDTH (trq_pkg::ID_W),
        .DEPTH (trq_pkg::THREAD_SLOTS)
    ) u_prev_ram (
        .clk   (clk),
        .we    (adv && upd.p_we),
        .waddr (upd.p_waddr),
        .wdata (upd.p_wdata),
        .re    (accept),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg  <= 1'b0;
            outv_reg <= 1'b0;
            st_reg   <= '0;
            idle_reg <= trq_pkg::IDLE_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                idle_reg <= idle_id;
            end
            if (accept)
            begin
                inv_reg <= 1'b1;
            end
            else if (adv)
            begin
                inv_reg <= 1'b0;
            end
            if (adv)
            begin
                st_reg   <= upd.st;
                outv_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                outv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.action <= action;
            item_reg.id     <= thread_id;
            // catch a link write landing on the address being read
            byp_n_reg  <= adv && upd.n_we && (upd.n_waddr == n_raddr);
            byp_nd_reg <= upd.n_wdata;
            byp_p_reg  <= adv && upd.p_we && (upd.p_waddr == p_raddr);
            byp_pd_reg <= upd.p_wdata;
        end
        if (adv)
        begin
            result_reg    <= upd.result;
            was_idle_reg  <= upd.was_idle;
            status_reg    <= upd.status;
            count_out_reg <= upd.st.count;
        end
    end

    assign out_valid    = outv_reg;
    assign result_id    = result_reg;
    assign was_idle     = was_idle_reg;
    assign status       = status_reg;
    assign queued_count = count_out_reg;

    `TRQ_ASSERT_ALWAYS(a_count_matches_members, $countones(st_reg.inq) == int'(st_reg.count), "count differs from membership")
    `TRQ_ASSERT_ALWAYS(a_empty_clears_ends, (st_reg.count != '0) || (st_reg.head == '0 && st_reg.tail == '0), "empty queue with nonzero head or tail")
    `TRQ_ASSERT(a_advance_gives_result, adv |=> outv_reg, "retired operation left no result")
    `TRQ_ASSERT(a_held_item_kept, (inv_reg && !adv) |=> inv_reg, "held operation was dropped")

endmodule
